/* rtl/slab_page_allocator_defines.svh */
// Assertion macros shared by the slab page allocator RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef SLAB_PAGE_ALLOCATOR_DEFINES_SVH
`define SLAB_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on the block clock outside reset.
`define SPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the block clock outside reset.
`define SPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/spa_pkg.sv */
// Package of the slab page allocator: sizes, codes, state and chunk tables.
// Depends on nothing; spa_addr_unit and slab_page_allocator import it.
package spa_pkg;

  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned SIZE_W     = 32;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned PG_OFS_W   = 12;
  localparam int unsigned MIN_SHIFT  = 4;
  localparam int unsigned MAX_CHUNK  = 2048;
  localparam int unsigned CLASSES    = 8;
  localparam int unsigned CLS_W      = 3;
  localparam int unsigned HEAP_PAGES = 256;
  localparam int unsigned PG_W       = 8;
  localparam int unsigned PCNT_W     = 9;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned LARGE_HDR  = 16;
  localparam int unsigned BACK_PTR   = 8;
  localparam int unsigned SLAB_HDR   = 24;
  localparam int unsigned NPAGE_W    = 21;

  typedef enum logic [2:0] {
    ST_ALLOC, ST_FREED, ST_NULL, ST_NOSPACE, ST_BADFREE
  } status_e;

  typedef enum logic [1:0] {
    KIND_UNUSED, KIND_SLAB, KIND_LARGE, KIND_TAIL
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_LTAIL, S_WALK_RD, S_WALK_CHK, S_NEW, S_POP, S_MARK,
    S_ADDR, S_FPG, S_FCHK, S_FBIT, S_FCLR, S_EMIT
  } state_e;

  // End of the slab page header, rounded up to a whole chunk.
  function automatic logic [PG_OFS_W-1:0] hdr_end(logic [CLS_W-1:0] cls);
    int unsigned s;
    s = int'(cls) + MIN_SHIFT;
    return PG_OFS_W'(((SLAB_HDR + (32'd1 << s) - 1) >> s) << s);
  endfunction

  // Number of chunks of a class that fit in a slab page.
  function automatic logic [PCNT_W-1:0] chunk_count(logic [CLS_W-1:0] cls);
    int unsigned s;
    s = int'(cls) + MIN_SHIFT;
    return PCNT_W'((PAGE_BYTES - int'(hdr_end(cls))) >> s);
  endfunction

  // Smallest class whose chunk holds the request plus its back pointer.
  function automatic logic [CLS_W-1:0] class_of(logic [PG_OFS_W-1:0] need);
    logic [CLS_W-1:0] c;
    c = '0;
    for (int i = CLASSES - 1; i >= 0; i--) begin
      if (32'(need) <= (32'd1 << (i + MIN_SHIFT))) c = CLS_W'(i);
    end
    return c;
  endfunction

endpackage

/* rtl/spa_req_if.sv */
// Request channel of the slab page allocator: valid/ready plus item fields.
// Depends on nothing.
interface spa_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] request_bytes;
  logic [47:0] release_address;

  modport source (output valid, mode, request_bytes, release_address, input ready);
  modport sink   (input valid, mode, request_bytes, release_address, output ready);
endinterface

/* rtl/spa_rsp_if.sv */
// Result channel of the slab page allocator: valid/ready plus item fields.
// Depends on nothing.
interface spa_rsp_if;
  logic        valid;
  logic        ready;
  logic [47:0] block_address;
  logic [2:0]  status;

  modport source (output valid, block_address, status, input ready);
  modport sink   (input valid, block_address, status, output ready);
endinterface

/* rtl/spa_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
// Depends on nothing; holds the per-page and per-chunk tables.
module spa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/spa_addr_unit.sv */
// Shared 48-bit address adder: forms block addresses and decodes offsets.
// Depends on spa_pkg.
module spa_addr_unit
  import spa_pkg::*;
(
  input  logic [ADDR_W-1:0] a_i,
  input  logic [ADDR_W-1:0] b_i,
  input  logic              sub_i,
  output logic [ADDR_W-1:0] y_o
);

  // Subtraction as addition of the inverse plus one; wraps modulo 2^48.
  assign y_o = a_i + (sub_i ? ~b_i : b_i) + ADDR_W'(sub_i);

endmodule

/* rtl/slab_page_allocator.sv */
// Slab page allocator over a 256-page heap: sequencer, page tables, adder.
// Depends on spa_pkg, spa_req_if, spa_rsp_if, spa_ram, spa_addr_unit and
// slab_page_allocator_defines.svh.
//
// Use: req_i carries one item per request (mode 0 allocate request_bytes,
// mode 1 free release_address); rsp_o returns one item per request with
// block_address and status. The heap base is written through base_addr_we_i
// and base_addr_i; the user must write it only while the block is idle,
// since the block itself does not enforce this.
// A small allocation walks its class list one page at a time, skipping full
// pages, opens a new slab page when no page on the list has room, and reuses
// a freed chunk before a fresh one. A large allocation marks every page it
// spans, and the free of a large block clears the kind valid bit of each.
// A null request (size 0 or address 0) is answered without a table write.
// One item is worked on at a time; req_i.ready is high only when idle, so the
// next item can be taken in the cycle after a result is loaded.
// A finished result waits in the output register while the next item is
// taken; if the receiver stalls and the register is still full, the next
// result waits until it drains.
// Reset clears the page count, the class list heads and all page-kind
// valid bits; no clearing pass is needed.
module slab_page_allocator
  import spa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              base_addr_we_i,
  input  logic [ADDR_W-1:0] base_addr_i,
  spa_req_if.sink           req_i,
  spa_rsp_if.source         rsp_o
);

`include "slab_page_allocator_defines.svh"

  localparam logic [PCNT_W-1:0] NONE = PCNT_W'(HEAP_PAGES);
  localparam int unsigned STK_AW = PG_W + SLOT_W;

  state_e              state_q, state_d;
  logic                mode_q;
  logic [SIZE_W-1:0]   size_q;
  logic [ADDR_W-1:0]   rel_q;
  logic [ADDR_W-1:0]   base_addr_q;
  logic [PCNT_W-1:0]   pages_used_q, pages_used_d;
  logic [PCNT_W-1:0]   head_q [CLASSES];
  logic [PCNT_W-1:0]   head_d [CLASSES];
  logic [HEAP_PAGES-1:0] kind_vld_q, kind_vld_d;
  logic                vld_rd_q;
  logic [PCNT_W-1:0]   pg_q, pg_d;
  logic [CLS_W-1:0]    cls_q, cls_d;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  logic [ADDR_W-1:0]   off_q, off_d;
  logic [PCNT_W-1:0]   ptr_q, ptr_d, end_q, end_d;
  logic [ADDR_W-1:0]   res_addr_q, res_addr_d;
  status_e             res_st_q, res_st_d;
  logic                out_vld_q;
  logic [ADDR_W-1:0]   out_addr_q;
  status_e             out_st_q;
  logic                in_fire, out_load;

  // Adder ports.
  logic [ADDR_W-1:0]   au_a, au_b, au_y;
  logic                au_sub;

  // Table ports.
  logic [PG_W-1:0]     rd_pg, wr_pg;
  logic                kind_we, class_we, span_we, link_we;
  logic                fleft_we, fresh_we, depth_we;
  kind_e               kind_wd;
  logic [PCNT_W-1:0]   span_wd, fleft_wd, fresh_wd, depth_wd;
  logic [1:0]          kind_rd;
  logic [CLS_W-1:0]    class_rd;
  logic [PCNT_W-1:0]   span_rd, link_rd, fleft_rd, fresh_rd, depth_rd;
  logic                stk_we, bit_we, bit_wd;
  logic [STK_AW-1:0]   stk_wa, stk_ra, bit_wa, bit_ra;
  logic [SLOT_W-1:0]   stk_wd, stk_rd;
  logic                bit_rd;

  // Request decode terms.
  logic                is_large;
  logic [NPAGE_W-1:0]  npages;
  logic [PCNT_W-1:0]   room;
  logic [CLS_W-1:0]    req_cls;
  kind_e               kind_eff;

  // Free decode terms.
  logic [PG_OFS_W-1:0] in_off, f_hdr, f_mask, f_idx;
  logic [PG_OFS_W:0]   f_d;
  logic                f_bad;
  logic [PG_OFS_W-1:0] m_off;

  assign in_fire  = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign out_load = (state_q == S_EMIT) && (!out_vld_q || rsp_o.ready);

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.block_address = out_addr_q;
  assign rsp_o.status        = out_st_q;

  // Shared address adder.
  spa_addr_unit u_addr (.a_i(au_a), .b_i(au_b), .sub_i(au_sub), .y_o(au_y));

  // Per-page tables.
  spa_ram #(.WIDTH(2), .DEPTH(HEAP_PAGES)) u_kind (
    .clk_i, .we_i(kind_we), .waddr_i(wr_pg), .wdata_i(kind_wd),
    .raddr_i(rd_pg), .rdata_o(kind_rd));
  spa_ram #(.WIDTH(CLS_W), .DEPTH(HEAP_PAGES)) u_class (
    .clk_i, .we_i(class_we), .waddr_i(wr_pg), .wdata_i(cls_q),
    .raddr_i(rd_pg), .rdata_o(class_rd));
  spa_ram #(.WIDTH(PCNT_W), .DEPTH(HEAP_PAGES)) u_span (
    .clk_i, .we_i(span_we), .waddr_i(wr_pg), .wdata_i(span_wd),
    .raddr_i(rd_pg), .rdata_o(span_rd));
  spa_ram #(.WIDTH(PCNT_W), .DEPTH(HEAP_PAGES)) u_link (
    .clk_i, .we_i(link_we), .waddr_i(wr_pg), .wdata_i(head_q[cls_q]),
    .raddr_i(rd_pg), .rdata_o(link_rd));
  spa_ram #(.WIDTH(PCNT_W), .DEPTH(HEAP_PAGES)) u_fleft (
    .clk_i, .we_i(fleft_we), .waddr_i(wr_pg), .wdata_i(fleft_wd),
    .raddr_i(rd_pg), .rdata_o(fleft_rd));
  spa_ram #(.WIDTH(PCNT_W), .DEPTH(HEAP_PAGES)) u_fresh (
    .clk_i, .we_i(fresh_we), .waddr_i(wr_pg), .wdata_i(fresh_wd),
    .raddr_i(rd_pg), .rdata_o(fresh_rd));
  spa_ram #(.WIDTH(PCNT_W), .DEPTH(HEAP_PAGES)) u_depth (
    .clk_i, .we_i(depth_we), .waddr_i(wr_pg), .wdata_i(depth_wd),
    .raddr_i(rd_pg), .rdata_o(depth_rd));

  // Per-chunk tables: freed-index stacks and the handed-out bitmap.
  spa_ram #(.WIDTH(SLOT_W), .DEPTH(HEAP_PAGES << SLOT_W)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .raddr_i(stk_ra), .rdata_o(stk_rd));
  spa_ram #(.WIDTH(1), .DEPTH(HEAP_PAGES << SLOT_W)) u_busy (
    .clk_i, .we_i(bit_we), .waddr_i(bit_wa), .wdata_i(bit_wd),
    .raddr_i(bit_ra), .rdata_o(bit_rd));

  // Decode of an allocation request.
  always_comb begin
    is_large = (33'(size_q) + 33'(LARGE_HDR)) > 33'(MAX_CHUNK);
    npages   = NPAGE_W'((33'(size_q) + 33'(LARGE_HDR + PAGE_BYTES - 1)) >> PG_OFS_W);
    room     = PCNT_W'(HEAP_PAGES) - pages_used_q;
    req_cls  = class_of(PG_OFS_W'(size_q + SIZE_W'(BACK_PTR)));
  end

  // Decode of a slab free from the page offset and the page's class.
  always_comb begin
    kind_eff = vld_rd_q ? kind_e'(kind_rd) : KIND_UNUSED;
    in_off   = off_q[PG_OFS_W-1:0];
    f_hdr    = hdr_end(class_rd);
    f_d      = (PG_OFS_W+1)'(in_off) - (PG_OFS_W+1)'(f_hdr)
             - (PG_OFS_W+1)'(BACK_PTR);
    f_mask   = (PG_OFS_W'(1) << (int'(class_rd) + MIN_SHIFT)) - PG_OFS_W'(1);
    f_idx    = f_d[PG_OFS_W-1:0] >> (int'(class_rd) + MIN_SHIFT);
    f_bad    = f_d[PG_OFS_W] || ((f_d[PG_OFS_W-1:0] & f_mask) != '0)
            || (f_idx >= PG_OFS_W'(chunk_count(class_rd)))
            || (f_idx >= PG_OFS_W'(fresh_rd));
    m_off    = hdr_end(cls_q)
             + PG_OFS_W'(20'(idx_q) << (int'(cls_q) + MIN_SHIFT))
             + PG_OFS_W'(BACK_PTR);
  end

  // Sequencer: next state, table writes and adder operands.
  always_comb begin
    state_d      = state_q;
    pages_used_d = pages_used_q;
    head_d       = head_q;
    kind_vld_d   = kind_vld_q;
    pg_d         = pg_q;
    cls_d        = cls_q;
    idx_d        = idx_q;
    off_d        = off_q;
    ptr_d        = ptr_q;
    end_d        = end_q;
    res_addr_d   = res_addr_q;
    res_st_d     = res_st_q;
    au_a         = base_addr_q;
    au_b         = ADDR_W'({pg_q[PG_W-1:0], off_q[PG_OFS_W-1:0]});
    au_sub       = 1'b0;
    rd_pg        = (state_q == S_FPG) ? off_q[PG_OFS_W+PG_W-1:PG_OFS_W] : pg_q[PG_W-1:0];
    wr_pg        = pg_q[PG_W-1:0];
    kind_we      = 1'b0;
    kind_wd      = KIND_SLAB;
    class_we     = 1'b0;
    span_we      = 1'b0;
    span_wd      = npages[PCNT_W-1:0];
    link_we      = 1'b0;
    fleft_we     = 1'b0;
    fleft_wd     = fleft_rd;
    fresh_we     = 1'b0;
    fresh_wd     = fresh_rd;
    depth_we     = 1'b0;
    depth_wd     = depth_rd;
    stk_we       = 1'b0;
    stk_wa       = {pg_q[PG_W-1:0], depth_rd[SLOT_W-1:0]};
    stk_wd       = idx_q;
    stk_ra       = {pg_q[PG_W-1:0], SLOT_W'(depth_rd - PCNT_W'(1))};
    bit_we       = 1'b0;
    bit_wa       = {pg_q[PG_W-1:0], idx_q};
    bit_wd       = 1'b0;
    bit_ra       = {pg_q[PG_W-1:0], f_idx[SLOT_W-1:0]};

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_DECODE;
      end
      S_DECODE: begin
        res_addr_d = '0;
        au_a       = rel_q;
        au_b       = base_addr_q;
        au_sub     = 1'b1;
        if (mode_q) begin
          off_d = au_y;
          if (rel_q == '0) begin
            res_st_d = ST_NULL;
            state_d  = S_EMIT;
          end else begin
            state_d = S_FPG;
          end
        end else if (size_q == '0) begin
          res_st_d = ST_NULL;
          state_d  = S_EMIT;
        end else if (is_large) begin
          if (npages > NPAGE_W'(room)) begin
            res_st_d = ST_NOSPACE;
            state_d  = S_EMIT;
          end else begin
            wr_pg        = pages_used_q[PG_W-1:0];
            kind_we      = 1'b1;
            kind_wd      = KIND_LARGE;
            span_we      = 1'b1;
            pg_d         = pages_used_q;
            off_d        = ADDR_W'(LARGE_HDR);
            ptr_d        = pages_used_q + PCNT_W'(1);
            end_d        = pages_used_q + npages[PCNT_W-1:0];
            pages_used_d = pages_used_q + npages[PCNT_W-1:0];
            state_d      = S_LTAIL;
          end
        end else begin
          cls_d   = req_cls;
          pg_d    = head_q[req_cls];
          state_d = S_WALK_RD;
        end
      end
      S_LTAIL: begin
        if (ptr_q < end_q) begin
          wr_pg   = ptr_q[PG_W-1:0];
          kind_we = 1'b1;
          kind_wd = KIND_TAIL;
          ptr_d   = ptr_q + PCNT_W'(1);
        end else begin
          state_d = S_ADDR;
        end
      end
      S_WALK_RD: begin
        state_d = pg_q[PG_W] ? S_NEW : S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (fleft_rd == '0) begin
          pg_d    = link_rd;
          state_d = S_WALK_RD;
        end else begin
          fleft_we = 1'b1;
          fleft_wd = fleft_rd - PCNT_W'(1);
          if (depth_rd != '0) begin
            depth_we = 1'b1;
            depth_wd = depth_rd - PCNT_W'(1);
            state_d  = S_POP;
          end else begin
            idx_d    = fresh_rd[SLOT_W-1:0];
            fresh_we = 1'b1;
            fresh_wd = fresh_rd + PCNT_W'(1);
            state_d  = S_MARK;
          end
        end
      end
      S_NEW: begin
        if (pages_used_q == NONE) begin
          res_st_d = ST_NOSPACE;
          state_d  = S_EMIT;
        end else begin
          wr_pg         = pages_used_q[PG_W-1:0];
          kind_we       = 1'b1;
          kind_wd       = KIND_SLAB;
          class_we      = 1'b1;
          link_we       = 1'b1;
          fleft_we      = 1'b1;
          fleft_wd      = chunk_count(cls_q);
          fresh_we      = 1'b1;
          fresh_wd      = '0;
          depth_we      = 1'b1;
          depth_wd      = '0;
          head_d[cls_q] = pages_used_q;
          pg_d          = pages_used_q;
          pages_used_d  = pages_used_q + PCNT_W'(1);
          state_d       = S_WALK_RD;
        end
      end
      S_POP: begin
        idx_d   = stk_rd;
        state_d = S_MARK;
      end
      S_MARK: begin
        bit_we  = 1'b1;
        bit_wd  = 1'b1;
        off_d   = ADDR_W'(m_off);
        state_d = S_ADDR;
      end
      S_ADDR: begin
        res_addr_d = au_y;
        res_st_d   = ST_ALLOC;
        state_d    = S_EMIT;
      end
      S_FPG: begin
        if ((off_q[ADDR_W-1:PG_OFS_W+PG_W] != '0)
            || (PCNT_W'(off_q[PG_OFS_W+PG_W-1:PG_OFS_W]) >= pages_used_q)) begin
          res_st_d = ST_BADFREE;
          state_d  = S_EMIT;
        end else begin
          pg_d    = PCNT_W'(off_q[PG_OFS_W+PG_W-1:PG_OFS_W]);
          state_d = S_FCHK;
        end
      end
      S_FCHK: begin
        res_st_d = ST_BADFREE;
        state_d  = S_EMIT;
        if (kind_eff == KIND_LARGE) begin
          if (in_off == PG_OFS_W'(LARGE_HDR)) begin
            ptr_d   = pg_q;
            end_d   = pg_q + span_rd;
            state_d = S_FCLR;
          end
        end else if (kind_eff == KIND_SLAB) begin
          if (!f_bad) begin
            idx_d   = f_idx[SLOT_W-1:0];
            state_d = S_FBIT;
          end
        end
      end
      S_FBIT: begin
        if (bit_rd) begin
          stk_we   = 1'b1;
          depth_we = 1'b1;
          depth_wd = depth_rd + PCNT_W'(1);
          fleft_we = 1'b1;
          fleft_wd = fleft_rd + PCNT_W'(1);
          bit_we   = 1'b1;
          bit_wd   = 1'b0;
          res_st_d = ST_FREED;
        end else begin
          res_st_d = ST_BADFREE;
        end
        state_d = S_EMIT;
      end
      S_FCLR: begin
        if (ptr_q < end_q) begin
          kind_vld_d[ptr_q[PG_W-1:0]] = 1'b0;
          ptr_d = ptr_q + PCNT_W'(1);
        end else begin
          res_st_d = ST_FREED;
          state_d  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (kind_we) kind_vld_d[wr_pg] = 1'b1;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pages_used_q <= '0;
      kind_vld_q   <= '0;
      vld_rd_q     <= 1'b0;
      base_addr_q  <= '0;
      out_vld_q    <= 1'b0;
      for (int i = 0; i < CLASSES; i++) head_q[i] <= NONE;
    end else begin
      state_q      <= state_d;
      pages_used_q <= pages_used_d;
      kind_vld_q   <= kind_vld_d;
      vld_rd_q     <= kind_vld_q[rd_pg];
      head_q       <= head_d;
      if (base_addr_we_i) base_addr_q <= base_addr_i;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Item and working registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= req_i.mode;
      size_q <= req_i.request_bytes;
      rel_q  <= req_i.release_address;
    end
    pg_q       <= pg_d;
    cls_q      <= cls_d;
    idx_q      <= idx_d;
    off_q      <= off_d;
    ptr_q      <= ptr_d;
    end_q      <= end_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    if (out_load) begin
      out_addr_q <= res_addr_q;
      out_st_q   <= res_st_q;
    end
  end

  // Checks on the sequencer and the result register.
  `SPA_ASSERT_NEXT(a_busy_after_accept, in_fire, state_q == S_DECODE, "item accepted but not decoded")
  `SPA_ASSERT_NOW(a_pages_bound, 1'b1, pages_used_q <= NONE, "page count beyond heap")
  `SPA_ASSERT_NOW(a_null_on_fail, out_vld_q && (out_st_q != ST_ALLOC), out_addr_q == '0, "nonzero address on a failed or free result")
  `SPA_ASSERT_NEXT(a_hold_stalled, out_vld_q && !rsp_o.ready, out_vld_q && $stable(out_addr_q), "stalled result lost")

endmodule
